FILE: rtl/hsvg_pkg.sv
// ----------------------------------------------------------------------------
// hsvg_pkg: shared types and constants for the HSV gradient to RGB core
// Transaction payloads, fixed field widths, hue sector constants.
// ----------------------------------------------------------------------------
package hsvg_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 12;

  localparam int unsigned HUE_W   = 15;  // 1/64 degree
  localparam int unsigned VALUE_W = 13;  // saturation, value, weight
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned REM_W   = 12;  // position inside a sector, 0..3840

  localparam int unsigned HUE_FULL    = 23040;  // 360 degrees
  localparam int unsigned SECTOR_SPAN = 3840;   // 60 degrees
  localparam int unsigned NUM_SECTORS = 6;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0]   start_hue;
    logic [VALUE_W-1:0] start_sat;
    logic [VALUE_W-1:0] start_val;
    logic [HUE_W-1:0]   end_hue;
    logic [VALUE_W-1:0] end_sat;
    logic [VALUE_W-1:0] end_val;
    logic [VALUE_W-1:0] blend_weight;
  } hsv_pair_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [3*CHAN_W-1:0] packed_rgb;
  } rgb_t;

  // Hue at the start of a sector
  function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SEC_RED_YEL: base = HUE_W'(0);
      SEC_YEL_GRN: base = HUE_W'(SECTOR_SPAN);
      SEC_GRN_CYN: base = HUE_W'(2 * SECTOR_SPAN);
      SEC_CYN_BLU: base = HUE_W'(3 * SECTOR_SPAN);
      SEC_BLU_MAG: base = HUE_W'(4 * SECTOR_SPAN);
      SEC_MAG_RED: base = HUE_W'(5 * SECTOR_SPAN);
      default:     base = HUE_W'(0);
    endcase
    return base;
  endfunction

endpackage

FILE: rtl/hsv_gradient_to_rgb_core.sv
// ----------------------------------------------------------------------------
// hsv_gradient_to_rgb_core: interpolated HSV color to 8-bit RGB
// Blends two HSV colors by a weight and converts the blend with the
// six-sector HSV rule into red, green, blue and a packed 0xRRGGBB word.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  req     | req_valid/req_stall  | hsv_pair_t: two HSV colors + weight
//  rgb     | rgb_valid/rgb_stall  | rgb_t: red, green, blue, packed_rgb
//
//  Six register stages, one transaction per cycle while rgb is not stalled.
//  Each stage holds a valid bit; a stage takes new data when it is empty or
//  the stage after it moves, so bubbles collapse under output stall.
//  req_stall rises only when all six stages hold data and rgb is stalled.
//  rst (synchronous) clears the valid bits; payload registers are not reset.
//
//  Stage map:
//    1  clamp, component difference times weight (three lerp multipliers)
//    2  add start value, drop fraction -> h, s, v
//    3  chroma = s*v, hue sector and in-sector position, full-value channel
//    4  m base = v - chroma, chroma times sector position
//    5  x and zero channels (scaling by 255/3840 folds into *17 and a shift)
//    6  sector routing into the output register
// ----------------------------------------------------------------------------
module hsv_gradient_to_rgb_core #(
  parameter int unsigned FRACTION_BITS = hsvg_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  hsvg_pkg::hsv_pair_t req,
  output logic                rgb_valid,
  input  logic                rgb_stall,
  output hsvg_pkg::rgb_t      rgb
);
  import hsvg_pkg::*;

  localparam int unsigned STAGES = 6;
  localparam int unsigned ONE    = 1 << FRACTION_BITS;
  localparam int unsigned CW     = 2 * VALUE_W;             // chroma
  localparam int unsigned MW     = VALUE_W + FRACTION_BITS; // v*one scale
  localparam int unsigned CQW    = CW + REM_W;              // chroma*q
  localparam int unsigned XW     = MW + REM_W;              // x numerator
  localparam int unsigned SH0    = 2 * FRACTION_BITS;
  localparam int unsigned SHX    = 2 * FRACTION_BITS + 8;   // /(256) part of /3840

  // --------------------------------------------------------------------------
  // Stage control: vld[k] marks stage k full, en[k] lets it load.
  // --------------------------------------------------------------------------
  logic [STAGES:1]   vld;
  logic [STAGES+1:1] en;

  always_comb begin
    en[STAGES+1] = !rgb_stall;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign req_stall = !en[1];
  assign rgb_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= req_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1-2: component interpolation
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] w_c;
  logic [1:0]         lerp_ld;
  logic [HUE_W-1:0]   s2_h;
  logic [VALUE_W-1:0] s2_s, s2_v;

  assign w_c     = (32'(req.blend_weight) > ONE) ? VALUE_W'(ONE) : req.blend_weight;
  assign lerp_ld = {en[2] && vld[1], en[1] && req_valid};

  hsvg_lerp #(.WIDTH(HUE_W), .TOP(HUE_FULL), .FRACTION_BITS(FRACTION_BITS)) u_lerp_hue (
    .clk (clk), .ld (lerp_ld), .a (req.start_hue), .b (req.end_hue), .w (w_c), .y (s2_h)
  );

  hsvg_lerp #(.WIDTH(VALUE_W), .TOP(ONE), .FRACTION_BITS(FRACTION_BITS)) u_lerp_sat (
    .clk (clk), .ld (lerp_ld), .a (req.start_sat), .b (req.end_sat), .w (w_c), .y (s2_s)
  );

  hsvg_lerp #(.WIDTH(VALUE_W), .TOP(ONE), .FRACTION_BITS(FRACTION_BITS)) u_lerp_val (
    .clk (clk), .ld (lerp_ld), .a (req.start_val), .b (req.end_val), .w (w_c), .y (s2_v)
  );

  // --------------------------------------------------------------------------
  // Stage 3: chroma, sector, position in sector, full-value channel
  // --------------------------------------------------------------------------
  logic [2:0]         sec_cnt;
  sector_t            sec;
  logic [REM_W-1:0]   rem, q;
  logic [VALUE_W+7:0] v255;

  logic [CW-1:0]      s3_chroma;
  logic [VALUE_W-1:0] s3_v;
  logic [REM_W-1:0]   s3_q;
  sector_t            s3_sec;
  logic [CHAN_W-1:0]  s3_chc;

  always_comb begin
    sec_cnt = 3'd0;
    // hue of 360 stops at the last sector, where the chroma part of x ends up zero
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (s2_h >= HUE_W'(k * SECTOR_SPAN)) sec_cnt = sec_cnt + 3'd1;
    end
    sec  = sector_t'(sec_cnt);
    rem  = REM_W'(s2_h - sector_base(sec));
    q    = sec_cnt[0] ? REM_W'(SECTOR_SPAN) - rem : rem;
    v255 = {s2_v, 8'd0} - (VALUE_W+8)'(s2_v);
  end

  always_ff @(posedge clk) begin
    if (en[3] && vld[2]) begin
      s3_chroma <= s2_s * s2_v;
      s3_v      <= s2_v;
      s3_q      <= q;
      s3_sec    <= sec;
      s3_chc    <= CHAN_W'(v255 >> FRACTION_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: m base and chroma*q
  // --------------------------------------------------------------------------
  logic [MW-1:0]     mbase;
  logic [MW-1:0]     s4_m;
  logic [CQW-1:0]    s4_cq;
  sector_t           s4_sec;
  logic [CHAN_W-1:0] s4_chc;

  // saturation never exceeds one, so chroma <= v*one
  assign mbase = {s3_v, {FRACTION_BITS{1'b0}}} - MW'(s3_chroma);

  always_ff @(posedge clk) begin
    if (en[4] && vld[3]) begin
      s4_m   <= mbase;
      s4_cq  <= s3_chroma * s3_q;
      s4_sec <= s3_sec;
      s4_chc <= s3_chc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: x = 255*(m*3840 + chroma*q)/(one^2*3840) = 17*(...) >> (2F+8)
  // --------------------------------------------------------------------------
  logic [XW-1:0]     xsum;
  logic [XW+4:0]     x17;
  logic [MW+7:0]     m255;
  logic [CHAN_W-1:0] s5_chx, s5_ch0, s5_chc;
  sector_t           s5_sec;

  always_comb begin
    // sum never exceeds v*one*3840, so XW bits hold it
    xsum = {s4_m, 12'd0} - XW'({s4_m, 8'd0}) + XW'(s4_cq);
    x17  = {xsum, 4'd0} + (XW+5)'(xsum);
    m255 = {s4_m, 8'd0} - (MW+8)'(s4_m);
  end

  always_ff @(posedge clk) begin
    if (en[5] && vld[4]) begin
      s5_chx <= CHAN_W'(x17 >> SHX);
      s5_ch0 <= CHAN_W'(m255 >> SH0);
      s5_chc <= s4_chc;
      s5_sec <= s4_sec;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: route channels by sector into the output register
  // --------------------------------------------------------------------------
  logic [CHAN_W-1:0] r_n, g_n, b_n;

  always_comb begin
    case (s5_sec)
      SEC_RED_YEL: begin r_n = s5_chc; g_n = s5_chx; b_n = s5_ch0; end
      SEC_YEL_GRN: begin r_n = s5_chx; g_n = s5_chc; b_n = s5_ch0; end
      SEC_GRN_CYN: begin r_n = s5_ch0; g_n = s5_chc; b_n = s5_chx; end
      SEC_CYN_BLU: begin r_n = s5_ch0; g_n = s5_chx; b_n = s5_chc; end
      SEC_BLU_MAG: begin r_n = s5_chx; g_n = s5_ch0; b_n = s5_chc; end
      default:     begin r_n = s5_chc; g_n = s5_ch0; b_n = s5_chx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6] && vld[5]) begin
      rgb.red        <= r_n;
      rgb.green      <= g_n;
      rgb.blue       <= b_n;
      rgb.packed_rgb <= {r_n, g_n, b_n};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (&vld))
    else $error("input stalled while a pipeline stage is empty");

  a_reset_clears : assert property (@(posedge clk)
    rst |=> !rgb_valid)
    else $error("output valid right after reset");

  a_packed_matches : assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> (rgb.packed_rgb[23:16] == rgb.red) && (rgb.packed_rgb[15:8] == rgb.green)
                  && (rgb.packed_rgb[7:0] == rgb.blue))
    else $error("packed word disagrees with channels");

  a_sector_range : assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s3_q <= REM_W'(SECTOR_SPAN)))
    else $error("sector position beyond one sector");

endmodule

FILE: rtl/hsvg_lerp.sv
// ----------------------------------------------------------------------------
// hsvg_lerp: two-stage linear interpolation of one color component
// Clamps both ends, multiplies the difference by the weight, then adds the
// start value and drops the fraction bits.
// ----------------------------------------------------------------------------
module hsvg_lerp #(
  parameter int unsigned WIDTH         = 13,
  parameter int unsigned TOP           = 4096,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                        clk,
  input  logic [1:0]                  ld,   // stage load enables
  input  logic [WIDTH-1:0]            a,
  input  logic [WIDTH-1:0]            b,
  input  logic [hsvg_pkg::VALUE_W-1:0] w,   // already clamped to one
  output logic [WIDTH-1:0]            y
);
  import hsvg_pkg::*;

  localparam int unsigned PW = WIDTH + VALUE_W + 2;
  localparam int unsigned AW = WIDTH + VALUE_W + FRACTION_BITS + 2;

  logic [WIDTH-1:0]        a_c, b_c;
  logic signed [WIDTH:0]   diff;
  logic signed [PW-1:0]    prod;
  logic [WIDTH-1:0]        a_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [AW-1:0]    acc;

  always_comb begin
    a_c  = (32'(a) > TOP) ? WIDTH'(TOP) : a;
    b_c  = (32'(b) > TOP) ? WIDTH'(TOP) : b;
    diff = $signed({1'b0, b_c}) - $signed({1'b0, a_c});
    prod = PW'(diff) * PW'($signed({1'b0, w}));
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_q    <= a_c;
      prod_q <= prod;
    end
  end

  // result is never negative and never above the larger end
  assign acc = $signed({{(AW - WIDTH - FRACTION_BITS){1'b0}}, a_q, {FRACTION_BITS{1'b0}}})
               + AW'(prod_q);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      y <= acc[FRACTION_BITS +: WIDTH];
    end
  end

endmodule
